// ===== rtl/tlv_container_parser_macros.svh =====
// Assertion macros shared by the TLV container parser RTL.
// Included by the modules that carry concurrent assertions.
`ifndef TLV_CONTAINER_PARSER_MACROS_SVH
`define TLV_CONTAINER_PARSER_MACROS_SVH

// Same-cycle property, disabled while reset is asserted.
`define TLVP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define TLVP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tlvp_pkg.sv =====
// Types, constants and the CRC-32 byte update for the TLV container parser.
// No dependencies; imported by every module of the block.
package tlvp_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 16384;
  localparam int unsigned HDR_BYTES       = 20;
  localparam int unsigned CRC_FIELD_POS   = 16;
  localparam int unsigned REC_HDR_BYTES   = 6;
  localparam int unsigned OQ_DEPTH        = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_ENDIAN  = 2'd2
  } tlvp_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_ENDIAN   = 3'd4,
    ST_HDR_SIZE = 3'd5,
    ST_PAY_SIZE = 3'd6,
    ST_CRC      = 3'd7
  } tlvp_status_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_SKIP
  } tlvp_phase_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_FINAL  = 1'b1
  } tlvp_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [31:0] total_size;
  } tlvp_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] record_type;
    logic [31:0] record_offset;
    logic [31:0] record_length;
    logic [2:0]  status;
    logic [14:0] record_count;
    logic        last;
  } tlvp_out_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [15:0] endian_mark;
  } tlvp_cfg_t;

  // Results produced by one accepted byte: cnt of them, res_a first.
  typedef struct packed {
    logic [1:0] cnt;
    tlvp_out_t  res_a;
    tlvp_out_t  res_b;
  } tlvp_emit_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/tlvp_parse.sv =====
// Byte parser: header capture and check, CRC-32, record splitting and status.
// Depends on tlvp_pkg and the assertion macros header.
`include "tlv_container_parser_macros.svh"

module tlvp_parse #(
  parameter int unsigned MAX_RECORDS = tlvp_pkg::MAX_RECORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlvp_pkg::tlvp_cfg_t  cfg_i,
  input  logic                 acc_i,
  input  tlvp_pkg::tlvp_in_t   in_i,
  output tlvp_pkg::tlvp_emit_t emit_o
);
  import tlvp_pkg::*;

  localparam int unsigned CNT_W     = $clog2(MAX_RECORDS + 1);
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int unsigned FILL_W    = $clog2(REC_HDR_BYTES);

  tlvp_phase_e        phase_q, phase_d, ph_cur, ph_after;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        size_q, size_d;
  logic [31:0]        crc_q, crc_d;
  tlvp_status_e       err_q, err_d;
  logic [CNT_W-1:0]   recs_q, recs_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [31:0]        dleft_q, dleft_d;
  logic [31:0]        hs_q, hs_d;
  logic [31:0]        endm1_q, endm1_d;
  logic [7:0]         hdr_q [HDR_BYTES];
  logic [7:0]         rec_q [REC_HDR_BYTES-1];

  logic               active, start, last_byte;
  logic [7:0]         b;
  logic [31:0]        p, size_cur, crc_base, crc_new, dleft_base;
  tlvp_status_e       err_base, err_after, hdr_st, fin_st;
  logic [CNT_W-1:0]   recs_base, recs_after;
  logic [FILL_W-1:0]  fill_base, fill_next;
  logic               in_hdr, chk, in_body, take_data, rec_byte, rec_done;
  logic               rec_bad, rec_ok, part_bad, rec_emit, fin_emit;
  logic [31:0]        h_magic, h_hs, h_ps, h_crc, left, rec_len;
  logic [15:0]        h_ver, h_end, rec_type;
  logic [32:0]        sum33;
  tlvp_out_t          rec_res, fin_res;

  assign b          = in_i.data_byte;
  assign start      = in_i.start_req;
  assign active     = acc_i && (start || (phase_q != PH_IDLE));
  assign p          = start ? '0 : pos_q;
  assign ph_cur     = start ? PH_HEADER : phase_q;
  assign size_cur   = start ? ((in_i.total_size == '0) ? 32'd1 : in_i.total_size) : size_q;
  assign last_byte  = (p == size_cur - 32'd1);
  assign crc_base   = start ? '1 : crc_q;
  assign err_base   = start ? ST_OK : err_q;
  assign recs_base  = start ? '0 : recs_q;
  assign fill_base  = start ? '0 : fill_q;
  assign dleft_base = start ? '0 : dleft_q;

  assign h_magic = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign h_ver   = {hdr_q[5], hdr_q[4]};
  assign h_end   = {hdr_q[7], hdr_q[6]};
  assign h_hs    = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign h_ps    = {hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12]};
  assign h_crc   = {b, hdr_q[CRC_FIELD_POS+2], hdr_q[CRC_FIELD_POS+1], hdr_q[CRC_FIELD_POS]};
  assign sum33   = {1'b0, h_hs} + {1'b0, h_ps};

  assign in_hdr  = (ph_cur == PH_HEADER);
  assign chk     = in_hdr && (p == 32'(HDR_BYTES - 1));
  assign crc_new = crc32_byte(crc_base, (p >= 32'(CRC_FIELD_POS)) ? 8'h00 : b);

  always_comb begin
    if (h_magic != cfg_i.magic_word) begin
      hdr_st = ST_MAGIC;
    end else if (h_ver != cfg_i.format_version) begin
      hdr_st = ST_VERSION;
    end else if (h_end != cfg_i.endian_mark) begin
      hdr_st = ST_ENDIAN;
    end else if ((h_hs < 32'(HDR_BYTES)) || (h_hs > size_cur)) begin
      hdr_st = ST_HDR_SIZE;
    end else if (sum33 > {1'b0, size_cur}) begin
      hdr_st = ST_PAY_SIZE;
    end else if (~crc_new != h_crc) begin
      hdr_st = ST_CRC;
    end else begin
      hdr_st = ST_OK;
    end
  end

  assign in_body   = (ph_cur == PH_BODY) && (p >= hs_q) && (p <= endm1_q);
  assign take_data = in_body && (dleft_base != '0);
  assign rec_byte  = in_body && (dleft_base == '0);
  assign rec_done  = rec_byte && (fill_base == FILL_W'(REC_HDR_BYTES - 1));
  assign rec_type  = {rec_q[1], rec_q[0]};
  assign rec_len   = {b, rec_q[4], rec_q[3], rec_q[2]};
  assign left      = endm1_q - p;
  assign rec_bad   = rec_done && ((rec_len > left) || (recs_base >= CNT_W'(MAX_RECORDS)));
  assign rec_ok    = rec_done && !rec_bad;
  assign fill_next = rec_done ? '0 : (rec_byte ? fill_base + FILL_W'(1) : fill_base);
  assign part_bad  = in_body && !rec_bad && (p == endm1_q) && (fill_next != '0);
  assign recs_after = rec_ok ? recs_base + CNT_W'(1) : recs_base;
  assign err_after = chk ? hdr_st : ((rec_bad || part_bad) ? ST_TRUNC : err_base);

  // Next phase.
  always_comb begin
    if (chk) begin
      ph_after = (hdr_st == ST_OK) ? PH_BODY : PH_SKIP;
    end else if (rec_bad || part_bad) begin
      ph_after = PH_SKIP;
    end else begin
      ph_after = ph_cur;
    end
    if (!active) begin
      phase_d = phase_q;
    end else if (last_byte) begin
      phase_d = PH_IDLE;
    end else begin
      phase_d = ph_after;
    end
  end

  // Datapath updates and results.
  always_comb begin
    pos_d   = pos_q;
    size_d  = size_q;
    crc_d   = crc_q;
    err_d   = err_q;
    recs_d  = recs_q;
    fill_d  = fill_q;
    dleft_d = dleft_q;
    hs_d    = hs_q;
    endm1_d = endm1_q;
    if (active) begin
      pos_d   = last_byte ? '0 : p + 32'd1;
      size_d  = size_cur;
      crc_d   = in_hdr ? crc_new : crc_base;
      err_d   = err_after;
      recs_d  = recs_after;
      fill_d  = fill_next;
      dleft_d = rec_ok ? rec_len : (take_data ? dleft_base - 32'd1 : dleft_base);
      if (chk) begin
        hs_d    = h_hs;
        endm1_d = sum33[31:0] - 32'd1;
      end
    end

    fin_st   = (ph_after == PH_HEADER) ? ST_TRUNC : err_after;
    rec_emit = active && rec_ok;
    fin_emit = active && last_byte;

    rec_res               = '0;
    rec_res.kind          = KIND_RECORD;
    rec_res.record_type   = rec_type;
    rec_res.record_offset = p + 32'd1;
    rec_res.record_length = rec_len;
    rec_res.status        = ST_OK;
    rec_res.last          = !fin_emit;

    fin_res              = '0;
    fin_res.kind         = KIND_FINAL;
    fin_res.status       = fin_st;
    fin_res.record_count = (fin_st == ST_OK) ? 15'(recs_after) : '0;
    fin_res.last         = 1'b1;

    emit_o.cnt   = {1'b0, rec_emit} + {1'b0, fin_emit};
    emit_o.res_a = rec_emit ? rec_res : fin_res;
    emit_o.res_b = fin_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      crc_q   <= '1;
      err_q   <= ST_OK;
      recs_q  <= '0;
      fill_q  <= '0;
      dleft_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      err_q   <= err_d;
      recs_q  <= recs_d;
      fill_q  <= fill_d;
      dleft_q <= dleft_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    hs_q    <= hs_d;
    endm1_q <= endm1_d;
    if (active && in_hdr) begin
      hdr_q[p[HDR_IDX_W-1:0]] <= b;
    end
    if (active && rec_byte && !rec_done) begin
      rec_q[fill_base] <= b;
    end
  end

  `TLVP_ASSERT(a_body_no_error, clk_i, rst_ni, (phase_q == PH_BODY) |-> (err_q == ST_OK), "Body phase entered with an error code")
  `TLVP_ASSERT(a_pair_order, clk_i, rst_ni, (emit_o.cnt == 2'd2) |-> (emit_o.res_a.kind == KIND_RECORD && emit_o.res_b.kind == KIND_FINAL), "Two results must be a record then a final status")
  `TLVP_ASSERT_NEXT(a_final_closes, clk_i, rst_ni, fin_emit, phase_q == PH_IDLE, "Container still open after its final status")

endmodule

// ===== rtl/tlvp_out_queue.sv =====
// Result queue: takes up to two results per cycle and hands out one per transfer.
// Depends on tlvp_pkg and the assertion macros header.
`include "tlv_container_parser_macros.svh"

module tlvp_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlvp_pkg::tlvp_emit_t emit_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tlvp_pkg::tlvp_out_t  out_data_o
);
  import tlvp_pkg::*;

  localparam int unsigned CW = $clog2(OQ_DEPTH + 1);
  localparam int unsigned PW = $clog2(OQ_DEPTH);

  tlvp_out_t       mem_q [OQ_DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign full_o      = (count_q > CW'(OQ_DEPTH - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wp_d    = wp_q + PW'(emit_i.cnt);
    rp_d    = rp_q + PW'(pop);
    count_d = count_q + CW'(emit_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.cnt != 2'd0) begin
      mem_q[wp_q] <= emit_i.res_a;
    end
    if (emit_i.cnt == 2'd2) begin
      mem_q[wp_q + PW'(1)] <= emit_i.res_b;
    end
  end

  `TLVP_ASSERT(a_no_overflow, clk_i, rst_ni, count_q <= CW'(OQ_DEPTH), "Result queue count beyond its depth")
  `TLVP_ASSERT(a_push_room, clk_i, rst_ni, (emit_i.cnt != 2'd0) |-> (count_q <= CW'(OQ_DEPTH - 2)), "Results pushed without room for two")
  `TLVP_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && (emit_i.cnt == 2'd0), count_q == $past(count_q) - CW'(1), "Queue count did not drop after a lone transfer")

endmodule

// ===== rtl/tlv_container_parser.sv =====
// Top level of the TLV container parser: configuration registers, parser, result queue.
// Depends on tlvp_pkg, tlvp_parse and tlvp_out_queue.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i/in_stall_o   in_data_i   (tlvp_in_t, one byte)
//   result    out        out_valid_o/out_stall_i out_data_o  (tlvp_out_t)
//   config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle unless stalled; its results enter a four-entry queue at the same edge.
// A byte gives at most two results, so the queue stalls input while fewer than two entries are free.
// Results leave one per cycle unless stalled; a byte that ends a container after a record gives two.
// Reset returns the parser to idle and empties the queue; configuration registers reset to zero.
module tlv_container_parser #(
  parameter int unsigned MAX_RECORDS = tlvp_pkg::MAX_RECORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tlvp_pkg::tlvp_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tlvp_pkg::tlvp_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tlvp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlvp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import tlvp_pkg::*;

  tlvp_cfg_t  cfg_q, cfg_d;
  tlvp_emit_t emit;
  logic       full, acc;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tlvp_cfg_reg_e'(cfg_idx_i))
        CFG_MAGIC:   cfg_d.magic_word     = cfg_wdata_i;
        CFG_VERSION: cfg_d.format_version = cfg_wdata_i[15:0];
        CFG_ENDIAN:  cfg_d.endian_mark    = cfg_wdata_i[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tlvp_parse #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .acc_i  (acc),
    .in_i   (in_data_i),
    .emit_o (emit)
  );

  tlvp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/tb_tlv_container_parser.sv =====
// Self-checking testbench for tlv_container_parser: sends containers, whole or cut short, and stray bytes byte by byte,
// predicts every record and final status, and compares each result transfer field by field.
// Depends on tlvp_pkg and the tlv_container_parser RTL only.
`timescale 1ns / 1ps

module tb_tlv_container_parser;
  import tlvp_pkg::*;

  localparam int unsigned REC_LIMIT = MAX_RECORDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [31:0] MAGIC_A = 32'h3156_4C54;
  localparam logic [15:0] VER_A = 16'h0102;
  localparam logic [15:0] END_A = 16'hFEFF;

  typedef enum int {
    FR_GOOD, FR_MAGIC, FR_VERSION, FR_ENDIAN, FR_HDR_SIZE, FR_PAY_SIZE, FR_CRC,
    FR_LONG_REC, FR_PART_REC, FR_CUT, FR_RESTART, FR_NOISE
  } frame_flavor_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tlvp_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  tlvp_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tlv_container_parser #(
    .MAX_RECORDS(REC_LIMIT)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow configuration and parser state.
  logic [31:0] cfg_magic;
  logic [15:0] cfg_version;
  logic [15:0] cfg_endian;
  logic [31:0] bpos_q;
  logic [31:0] csize_q;
  logic [7:0]  hbytes [0:HDR_BYTES-1];
  logic [31:0] crc_q;
  logic [47:0] rec_hdr_q;
  int unsigned rec_fill_q;
  logic [31:0] data_left_q;
  logic [16:0] rec_seen_q;
  tlvp_status_e err_q;
  tlvp_phase_e  phase_q;

  tlvp_out_t   awaited_results [$];
  tlvp_out_t   want_res;
  logic [7:0]  frame_q [$];
  int unsigned body_start;
  int unsigned bytes_sent;
  int unsigned err_cnt;
  int unsigned res_idx;
  int unsigned cycles;
  bit          idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [31:0] hdr_le32(input int i);
    return {hbytes[i+3], hbytes[i+2], hbytes[i+1], hbytes[i]};
  endfunction

  function automatic tlvp_out_t make_result(input tlvp_kind_e k, input logic [15:0] typ,
                                            input logic [31:0] off, input logic [31:0] len,
                                            input tlvp_status_e st, input logic [14:0] cnt);
    tlvp_out_t r;
    r.kind = k;
    r.record_type = typ;
    r.record_offset = off;
    r.record_length = len;
    r.status = st;
    r.record_count = cnt;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic reset_parse_state();
    bpos_q = '0;
    csize_q = '0;
    for (int i = 0; i < HDR_BYTES; i++) hbytes[i] = 8'h00;
    crc_q = '1;
    rec_hdr_q = '0;
    rec_fill_q = 0;
    data_left_q = '0;
    rec_seen_q = '0;
    err_q = ST_OK;
    phase_q = PH_IDLE;
  endtask

  // Advances the predicted parser by one accepted byte and queues the results it causes.
  task automatic parse_byte(input tlvp_in_t it);
    tlvp_out_t res_a;
    tlvp_out_t res_b;
    tlvp_out_t fin;
    int n;
    logic [31:0] p;
    logic [31:0] rlen;
    logic [15:0] rtype;
    logic [32:0] hsz;
    logic [32:0] pend;
    tlvp_status_e st;
    bit stopped;
    n = 0;
    stopped = 1'b0;
    if (it.start_req) begin
      reset_parse_state();
      csize_q = (it.total_size == 32'd0) ? 32'd1 : it.total_size;
      phase_q = PH_HEADER;
    end else if (phase_q == PH_IDLE) begin
      return;
    end
    p = bpos_q;
    if (phase_q == PH_HEADER) begin
      hbytes[p] = it.data_byte;
      crc_q = crc_next(crc_q, (p >= CRC_FIELD_POS) ? 8'h00 : it.data_byte);
      if (p == HDR_BYTES - 1) begin
        hsz = {1'b0, hdr_le32(8)};
        pend = hsz + {1'b0, hdr_le32(12)};
        if (hdr_le32(0) != cfg_magic) st = ST_MAGIC;
        else if ({hbytes[5], hbytes[4]} != cfg_version) st = ST_VERSION;
        else if ({hbytes[7], hbytes[6]} != cfg_endian) st = ST_ENDIAN;
        else if (hsz < HDR_BYTES || hsz > {1'b0, csize_q}) st = ST_HDR_SIZE;
        else if (pend > {1'b0, csize_q}) st = ST_PAY_SIZE;
        else if (~crc_q != hdr_le32(16)) st = ST_CRC;
        else st = ST_OK;
        err_q = st;
        phase_q = (st == ST_OK) ? PH_BODY : PH_SKIP;
      end
    end else if (phase_q == PH_BODY) begin
      hsz = {1'b0, hdr_le32(8)};
      pend = hsz + {1'b0, hdr_le32(12)};
      if ({1'b0, p} >= hsz && {1'b0, p} < pend) begin
        if (data_left_q != 32'd0) begin
          data_left_q--;
        end else begin
          rec_hdr_q[rec_fill_q*8 +: 8] = it.data_byte;
          rec_fill_q++;
          if (rec_fill_q == REC_HDR_BYTES) begin
            rtype = rec_hdr_q[15:0];
            rlen = rec_hdr_q[47:16];
            rec_fill_q = 0;
            rec_hdr_q = '0;
            if ({1'b0, rlen} > pend - {1'b0, p} - 33'd1 || rec_seen_q >= REC_LIMIT) begin
              err_q = ST_TRUNC;
              phase_q = PH_SKIP;
              stopped = 1'b1;
            end else begin
              rec_seen_q++;
              data_left_q = rlen;
              res_a = make_result(KIND_RECORD, rtype, p + 32'd1, rlen, ST_OK, 15'd0);
              n = 1;
            end
          end
        end
        if (!stopped && {1'b0, p} + 33'd1 == pend && rec_fill_q != 0) begin
          err_q = ST_TRUNC;
          phase_q = PH_SKIP;
        end
      end
    end
    if (p == csize_q - 32'd1) begin
      st = (phase_q == PH_HEADER) ? ST_TRUNC : err_q;
      fin = make_result(KIND_FINAL, 16'd0, 32'd0, 32'd0, st,
                        (st == ST_OK) ? rec_seen_q[14:0] : 15'd0);
      if (n == 0) res_a = fin;
      else res_b = fin;
      n++;
      reset_parse_state();
    end else begin
      bpos_q = p + 32'd1;
    end
    if (n == 1) begin
      res_a.last = 1'b1;
      awaited_results.push_back(res_a);
    end else if (n == 2) begin
      res_b.last = 1'b1;
      awaited_results.push_back(res_a);
      awaited_results.push_back(res_b);
    end
  endtask

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch at result %0d: %s", res_idx, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want_res = awaited_results.pop_front();
        check_field("kind", out_data.kind, want_res.kind);
        check_field("record_type", out_data.record_type, want_res.record_type);
        check_field("record_offset", out_data.record_offset, want_res.record_offset);
        check_field("record_length", out_data.record_length, want_res.record_length);
        check_field("status", out_data.status, want_res.status);
        check_field("record_count", out_data.record_count, want_res.record_count);
        check_field("last", out_data.last, want_res.last);
      end
      res_idx++;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 11) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic [31:0] tot);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 15) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_data.data_byte = b;
    in_data.start_req = st;
    in_data.total_size = tot;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(in_data);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input tlvp_cfg_reg_e r, input logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_wdata = v;
    @(posedge clk);
    case (r)
      CFG_MAGIC: cfg_magic = v;
      CFG_VERSION: cfg_version = v[15:0];
      CFG_ENDIAN: cfg_endian = v[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] mg, input logic [15:0] ver, input logic [15:0] en);
    wait_drained();
    write_cfg(CFG_MAGIC, mg);
    write_cfg(CFG_VERSION, {16'h0, ver});
    write_cfg(CFG_ENDIAN, {16'h0, en});
  endtask

  task automatic put_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_random(input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_q.push_back($urandom_range(0, 255));
  endtask

  task automatic put_record(input logic [15:0] typ, input logic [31:0] len, input int ndata);
    put_le({16'h0, typ}, 2);
    put_le(len, 4);
    put_random(ndata);
  endtask

  // Header with payload size and CRC left open; a small header size gets random padding.
  task automatic start_frame(input logic [31:0] mg, input logic [15:0] ver,
                             input logic [15:0] en, input logic [31:0] hs);
    frame_q.delete();
    put_le(mg, 4);
    put_le({16'h0, ver}, 2);
    put_le({16'h0, en}, 2);
    put_le(hs, 4);
    put_le(32'h0, 8);
    if (hs > HDR_BYTES && hs <= 28) put_random(hs - HDR_BYTES);
    body_start = frame_q.size();
  endtask

  task automatic finish_frame(input logic [31:0] ps, input bit bad_crc);
    logic [31:0] c;
    for (int i = 0; i < 4; i++) frame_q[12+i] = ps[8*i +: 8];
    c = '1;
    for (int i = 0; i < 16; i++) c = crc_next(c, frame_q[i]);
    for (int i = 0; i < 4; i++) c = crc_next(c, 8'h00);
    c = ~c;
    if (bad_crc) c ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) frame_q[16+i] = c[8*i +: 8];
  endtask

  task automatic send_frame(input logic [31:0] tot, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(frame_q[i], i == 0, (i == 0) ? tot : $urandom);
    end
    bytes_sent += nbytes;
  endtask

  task automatic one_record_frame(input logic [31:0] mg, input logic [15:0] ver,
                                  input logic [15:0] en, input logic [31:0] hs,
                                  input logic [31:0] ps, input bit bad_crc);
    start_frame(mg, ver, en, hs);
    put_record($urandom, 32'd0, 0);
    finish_frame(ps, bad_crc);
    send_frame(frame_q.size(), frame_q.size());
  endtask

  task automatic random_frame(input frame_flavor_e fl);
    logic [31:0] mg;
    logic [31:0] hs;
    logic [31:0] ps;
    logic [15:0] ver;
    logic [15:0] en;
    int unsigned nrec;
    int unsigned len;
    int unsigned trail;
    int unsigned cut;
    if (fl == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte($urandom, 1'b0, $urandom);
      return;
    end
    mg = cfg_magic;
    ver = cfg_version;
    en = cfg_endian;
    hs = HDR_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    trail = $urandom_range(0, 3);
    case (fl)
      FR_MAGIC: mg ^= 32'h1 << $urandom_range(0, 31);
      FR_VERSION: ver ^= 16'h1 << $urandom_range(0, 15);
      FR_ENDIAN: en ^= 16'h1 << $urandom_range(0, 15);
      FR_HDR_SIZE: hs = $urandom_range(0, 1) ? $urandom_range(0, 19) : ($urandom | 32'h1000);
      default: ;
    endcase
    start_frame(mg, ver, en, hs);
    nrec = $urandom_range(0, 3);
    for (int k = 0; k < nrec; k++) begin
      len = $urandom_range(0, 5);
      put_record($urandom, len, len);
    end
    if (fl == FR_PART_REC) put_random($urandom_range(1, 5));
    if (fl == FR_LONG_REC) begin
      put_record($urandom, $urandom_range(0, 1) ? $urandom_range(1, 4) : ($urandom | 32'h8000_0000),
                 0);
    end
    ps = frame_q.size() - body_start;
    if (fl == FR_PAY_SIZE) begin
      ps = $urandom_range(0, 1) ? (ps + trail + $urandom_range(1, 3)) : ($urandom | 32'hFF00_0000);
    end
    finish_frame(ps, fl == FR_CRC);
    put_random(trail);
    cut = $urandom_range(1, frame_q.size() - 1);
    if (fl == FR_CUT) send_frame(cut, cut);
    else if (fl == FR_RESTART) send_frame($urandom | 32'h100, cut);
    else send_frame(frame_q.size(), frame_q.size());
  endtask

  // Stray bytes, a zero size, a short container and a good one under the reset configuration.
  task automatic test_idle_and_tiny();
    repeat (3) send_byte($urandom, 1'b0, $urandom);
    send_byte($urandom, 1'b1, 32'd0);
    start_frame(32'h0, 16'h0, 16'h0, HDR_BYTES);
    send_frame(32'd7, 7);
    start_frame(cfg_magic, cfg_version, cfg_endian, HDR_BYTES);
    put_record(16'hFFFF, 32'd2, 2);
    finish_frame(frame_q.size() - body_start, 1'b0);
    send_frame(frame_q.size(), frame_q.size());
  endtask

  task automatic test_header_checks();
    one_record_frame(MAGIC_A ^ 32'h8000_0000, VER_A, END_A, 20, 6, 1'b0);
    one_record_frame(MAGIC_A, VER_A ^ 16'h0001, END_A, 20, 6, 1'b0);
    one_record_frame(MAGIC_A, VER_A, END_A ^ 16'h8000, 20, 6, 1'b0);
    one_record_frame(MAGIC_A, VER_A, END_A, 19, 6, 1'b0);
    one_record_frame(MAGIC_A, VER_A, END_A, 32'hFFFF_FFFF, 6, 1'b0);
    one_record_frame(MAGIC_A, VER_A, END_A, 20, 7, 1'b0);
    // The size sum wraps in 32 bits and must still be rejected.
    one_record_frame(MAGIC_A, VER_A, END_A, 20, 32'hFFFF_FFF0, 1'b0);
    one_record_frame(MAGIC_A, VER_A, END_A, 20, 6, 1'b1);
    one_record_frame(MAGIC_A, VER_A, END_A, 20, 6, 1'b0);
  endtask

  task automatic test_record_layout();
    start_frame(MAGIC_A, VER_A, END_A, 23);
    put_record(16'h0000, 32'd0, 0);
    put_record(16'hFFFF, 32'd3, 3);
    finish_frame(frame_q.size() - body_start, 1'b0);
    put_random(2);
    send_frame(frame_q.size(), frame_q.size());
    // The last record header ends on the container's last byte.
    start_frame(MAGIC_A, VER_A, END_A, 20);
    put_record(16'h1234, 32'd1, 1);
    put_record(16'h8001, 32'd0, 0);
    finish_frame(frame_q.size() - body_start, 1'b0);
    send_frame(frame_q.size(), frame_q.size());
    start_frame(MAGIC_A, VER_A, END_A, 20);
    put_record(16'h00FF, 32'd2, 2);
    put_random(3);
    finish_frame(frame_q.size() - body_start, 1'b0);
    send_frame(frame_q.size(), frame_q.size());
    start_frame(MAGIC_A, VER_A, END_A, 20);
    put_record(16'h5A5A, 32'hFFFF_FFFF, 0);
    finish_frame(32'd6, 1'b0);
    put_random(2);
    send_frame(frame_q.size(), frame_q.size());
    start_frame(MAGIC_A, VER_A, END_A, 20);
    put_record(16'hA5A5, 32'd1, 0);
    finish_frame(32'd6, 1'b0);
    send_frame(frame_q.size(), frame_q.size());
    start_frame(MAGIC_A, VER_A, END_A, 24);
    finish_frame(32'd0, 1'b0);
    send_frame(frame_q.size(), frame_q.size());
  endtask

  // A new start drops the open container, in the header and in the body.
  task automatic test_restart();
    start_frame(MAGIC_A, VER_A, END_A, 20);
    put_record(16'h0101, 32'd4, 4);
    finish_frame(frame_q.size() - body_start, 1'b0);
    send_frame(32'hFFFF_FFFF, 12);
    send_frame(32'h8000_0000, 28);
    send_frame(frame_q.size(), frame_q.size());
  endtask

  task automatic test_random(input logic [31:0] mg, input logic [15:0] ver,
                             input logic [15:0] en, input int unsigned budget, input bit idling);
    int unsigned stop_at;
    int unsigned roll;
    idle_en = idling;
    set_config(mg, ver, en);
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      idle_en = idling && ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      random_frame((roll < 55) ? FR_GOOD : frame_flavor_e'(1 + roll % 11));
    end
    random_frame(FR_GOOD);
  endtask

  // Exactly the record limit, then one record beyond it.
  task automatic test_record_limit();
    idle_en = 1'b0;
    for (int extra = 0; extra < 2; extra++) begin
      start_frame(cfg_magic, cfg_version, cfg_endian, HDR_BYTES);
      for (int k = 0; k < REC_LIMIT + extra; k++) put_record($urandom, 32'd0, 0);
      finish_frame(frame_q.size() - body_start, 1'b0);
      send_frame(frame_q.size(), frame_q.size());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cfg_magic = '0;
    cfg_version = '0;
    cfg_endian = '0;
    idle_en = 1'b1;
    err_cnt = 0;
    res_idx = 0;
    cycles = 0;
    bytes_sent = 0;
    reset_parse_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_and_tiny();
    set_config(MAGIC_A, VER_A, END_A);
    test_header_checks();
    test_record_layout();
    test_restart();
    test_random(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 150, 1'b1);
    test_random($urandom, $urandom, $urandom, 150, 1'b1);
    test_random(32'h0, 16'h0, 16'h0, 150, 1'b1);
    test_random(MAGIC_A, VER_A, END_A, 100, 1'b0);
    test_record_limit();
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
